[src/dvlq_pkg.sv]
// shared constants and types for the delta vlq offset encoder
package dvlq_pkg;

  // field widths fixed by the item format
  localparam int unsigned OffsetW   = 32;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned GroupBits = 7;

  // low seven bits of a code byte
  localparam logic [GroupBits-1:0] GroupMask = 7'h7F;
  // continuation flag, bit 7 of a code byte
  localparam logic [ByteW-1:0]     MoreBit   = 8'h80;

  // request actions
  typedef enum logic {
    ACT_ENCODE = 1'b0,
    ACT_FINISH = 1'b1
  } action_e;

endpackage

[src/dvlq_if.sv]
// request and result channel interfaces

interface dvlq_in_if;
  logic                            valid;
  logic                            ready;
  logic                            action;
  logic [dvlq_pkg::OffsetW-1:0]    offset_value;

  modport source (output valid, output action, output offset_value, input ready);
  modport sink   (input valid, input action, input offset_value, output ready);
endinterface

interface dvlq_out_if;
  logic                            valid;
  logic                            ready;
  logic [dvlq_pkg::ByteW-1:0]      code_byte;
  logic                            last_of_run;
  logic                            overflow;

  modport source (output valid, output code_byte, output last_of_run, output overflow,
                  input ready);
  modport sink   (input valid, input code_byte, input last_of_run, input overflow,
                  output ready);
endinterface

[src/delta_vlq_offset_encoder_top.sv]
// Delta VLQ offset encoder: each encode request sends the wrapped difference to the
// previous offset as big-endian 7-bit groups, leading zero groups dropped, bit 7 set on
// all but the final byte; overflow marks every byte of a descending or too-wide delta.
// A finish request sends one zero byte and clears the previous offset. An encode
// request produces 1 to GROUPS bytes (a finish produces one), sent through the single
// byte-wide result port. The front end takes one request per cycle into a two-entry
// queue, so up to two requests can wait while the back end sends bytes or the result
// side stalls; the input stalls only while the queue is full. The first byte of a
// request is valid once its entry has passed from the queue into the back-end
// registers.
module delta_vlq_offset_encoder_top #(
  parameter int unsigned GROUPS = 4
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  dvlq_in_if.sink      in_i,
  dvlq_out_if.source   out_o
);

  localparam int unsigned GrpW   = (GROUPS > 1) ? $clog2(GROUPS) : 1;
  localparam int unsigned EntryW = dvlq_pkg::GroupBits * GROUPS + GrpW + 1;

  logic              push_valid, push_ready;
  logic [EntryW-1:0] push_data;
  logic              pop_valid, pop_ready;
  logic [EntryW-1:0] pop_data;

  // request classification and delta
  dvlq_front #(.GROUPS(GROUPS)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (in_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  // decoupling queue
  dvlq_queue #(.WIDTH(EntryW)) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  // byte emission
  dvlq_back #(.GROUPS(GROUPS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_data),
    .res_o       (out_o)
  );

endmodule

[src/dvlq_front.sv]
// front end: delta against the previous offset, overflow check, group count
module dvlq_front #(
  parameter int unsigned GROUPS = 4
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  dvlq_in_if.sink                     req_i,
  output logic                        push_valid_o,
  input  logic                        push_ready_i,
  output logic [7*GROUPS+((GROUPS>1)?$clog2(GROUPS):1):0] push_data_o
);

  localparam int unsigned DataW = dvlq_pkg::GroupBits * GROUPS;
  localparam int unsigned GrpW  = (GROUPS > 1) ? $clog2(GROUPS) : 1;

  logic [dvlq_pkg::OffsetW-1:0] prev_q, prev_d;
  logic [dvlq_pkg::OffsetW-1:0] delta;
  logic [63:0]                  delta_wide;
  logic [DataW-1:0]             delta_cut;
  logic                         ovf;
  logic [GrpW-1:0]              lead;
  logic                         fire;
  logic                         is_finish;

  assign is_finish = (req_i.action == dvlq_pkg::ACT_FINISH);
  assign fire      = req_i.valid & push_ready_i;

  // wrapped delta, cut to the group field, zero for a finish request
  assign delta      = req_i.offset_value - prev_q;
  assign delta_wide = {32'b0, delta};
  assign delta_cut  = is_finish ? '0 : delta_wide[DataW-1:0];

  // overflow on descending offset or bits above the group field
  always_comb begin
    ovf = (req_i.offset_value < prev_q);
    if ((delta_wide >> DataW) != 64'b0) begin
      ovf = 1'b1;
    end
    if (is_finish) begin
      ovf = 1'b0;
    end
  end

  // index of the highest nonzero group, zero when all are zero
  always_comb begin
    lead = '0;
    for (int i = 1; i < int'(GROUPS); i++) begin
      if (delta_cut[i*dvlq_pkg::GroupBits +: dvlq_pkg::GroupBits] != '0) begin
        lead = GrpW'(i);
      end
    end
  end

  // previous offset tracking
  always_comb begin
    prev_d = prev_q;
    if (fire) begin
      prev_d = is_finish ? '0 : req_i.offset_value;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
    end else begin
      prev_q <= prev_d;
    end
  end

  assign req_i.ready  = push_ready_i;
  assign push_valid_o = req_i.valid;
  assign push_data_o  = {ovf, lead, delta_cut};

endmodule

[src/dvlq_queue.sv]
// two-entry queue between the front and back ends
module dvlq_queue #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);

  logic [WIDTH-1:0] mem_q [2];
  logic             wr_ptr_q, wr_ptr_d;
  logic             rd_ptr_q, rd_ptr_d;
  logic [1:0]       cnt_q, cnt_d;
  logic             push, pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i & push_ready_o;
  assign pop          = pop_valid_o & pop_ready_i;

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push;
    rd_ptr_d = rd_ptr_q ^ pop;
    cnt_d    = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

[src/dvlq_back.sv]
// back end: walks the groups of one delta and sends one code byte per cycle unless the result side stalls
module dvlq_back #(
  parameter int unsigned GROUPS = 4
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        pop_valid_i,
  output logic                        pop_ready_o,
  input  logic [7*GROUPS+((GROUPS>1)?$clog2(GROUPS):1):0] pop_data_i,
  dvlq_out_if.source                  res_o
);

  localparam int unsigned DataW = dvlq_pkg::GroupBits * GROUPS;
  localparam int unsigned GrpW  = (GROUPS > 1) ? $clog2(GROUPS) : 1;

  logic                         busy_q, busy_d;
  logic [GrpW-1:0]              grp_q, grp_d;
  logic [DataW-1:0]             data_q, data_d;
  logic                         ovf_q, ovf_d;
  logic                         done;
  logic                         load;
  logic [dvlq_pkg::GroupBits-1:0] group;

  // current group and byte assembly
  assign group = data_q[grp_q*dvlq_pkg::GroupBits +: dvlq_pkg::GroupBits]
                 & dvlq_pkg::GroupMask;
  assign res_o.valid       = busy_q;
  assign res_o.code_byte   = (grp_q != '0) ? (dvlq_pkg::MoreBit | {1'b0, group})
                                           : {1'b0, group};
  assign res_o.last_of_run = (grp_q == '0);
  assign res_o.overflow    = ovf_q;

  // take the next entry when idle or when the final byte leaves
  assign done        = busy_q & res_o.ready & (grp_q == '0);
  assign load        = !busy_q || done;
  assign pop_ready_o = load;

  always_comb begin
    busy_d = busy_q;
    grp_d  = grp_q;
    data_d = data_q;
    ovf_d  = ovf_q;
    if (load) begin
      busy_d = pop_valid_i;
      data_d = pop_data_i[DataW-1:0];
      grp_d  = pop_data_i[DataW +: GrpW];
      ovf_d  = pop_data_i[DataW+GrpW];
    end else if (res_o.ready) begin
      grp_d = grp_q - GrpW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    grp_q  <= grp_d;
    data_q <= data_d;
    ovf_q  <= ovf_d;
  end

endmodule
